FILE: rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared widths, constants and types of the pressure compensation pipeline.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int RAW_W        = 20;
    localparam int TEMP_W       = 15;
    localparam int PRESS_W      = 32;
    localparam int COEF_W       = 16;
    localparam int CFG_W        = 64;
    localparam int CFG_IDX_W    = 2;
    localparam int WORD_W       = 64;
    localparam int DEN_W        = 31;
    localparam int DIV_BITS_DEF = 4;

    localparam int T_OFFSET = 128000;
    localparam int TEMP_MIN = -4000;
    localparam int TEMP_MAX = 8500;

    localparam logic [RAW_W:0] P_BASE    = 21'd1048576;
    localparam logic [11:0]    NUM_SCALE = 12'd3125;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP       = 2'd0,
        CFG_PRESS_LOW  = 2'd1,
        CFG_PRESS_HIGH = 2'd2,
        CFG_PRESS_LAST = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic                     invalid;
    } t_side;

endpackage

FILE: rtl/bpc_if.sv
// ----------------------------------------------------------------------------
// bpc channel interfaces
// Request (raw readings) and response (compensated values) channels.
// ----------------------------------------------------------------------------
interface bpc_in_if;
    logic                         valid;
    logic                         ready;
    logic [bpc_pkg::RAW_W-1:0]    raw_temperature;
    logic [bpc_pkg::RAW_W-1:0]    raw_pressure;

    modport source (output valid, raw_temperature, raw_pressure, input ready);
    modport sink   (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bpc_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [bpc_pkg::TEMP_W-1:0] temperature_centi;
    logic [bpc_pkg::PRESS_W-1:0]      pressure_q8;
    logic                             pressure_invalid;

    modport source (output valid, temperature_centi, pressure_q8, pressure_invalid,
                    input ready);
    modport sink   (input valid, temperature_centi, pressure_q8, pressure_invalid,
                    output ready);
endinterface

FILE: rtl/bpc_divider.sv
// ----------------------------------------------------------------------------
// bpc_divider
// Pipelined signed 64 / 31-bit restoring divider, truncating toward zero.
// ----------------------------------------------------------------------------
module bpc_divider #(
    parameter int STEP_BITS = bpc_pkg::DIV_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [bpc_pkg::WORD_W-1:0]   i_num,
    input  logic signed [bpc_pkg::DEN_W-1:0]    i_den,
    input  bpc_pkg::t_side                      i_side,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [bpc_pkg::WORD_W-1:0]   o_quo,
    output bpc_pkg::t_side                      o_side
);

    localparam int NSTEP = bpc_pkg::WORD_W / STEP_BITS;
    localparam int NST   = NSTEP + 2;

    typedef struct packed {
        logic [bpc_pkg::WORD_W-1:0] work;
        logic [bpc_pkg::DEN_W-1:0]  rem;
        logic [bpc_pkg::DEN_W-1:0]  den;
        logic                       neg;
        bpc_pkg::t_side             side;
    } t_div_stage;

    function automatic t_div_stage div_step(input t_div_stage s);
        t_div_stage              o;
        logic [bpc_pkg::DEN_W:0] trial;
        o = s;
        for (int b = 0; b < STEP_BITS; b++) begin
            trial  = {o.rem, o.work[bpc_pkg::WORD_W-1]};
            o.work = {o.work[bpc_pkg::WORD_W-2:0], 1'b0};
            if (trial >= {1'b0, o.den}) begin
                trial     = trial - {1'b0, o.den};
                o.work[0] = 1'b1;
            end
            o.rem = trial[bpc_pkg::DEN_W-1:0];
        end
        return o;
    endfunction

    t_div_stage         r_st [NST];
    t_div_stage         n_st [NST];
    logic [NST-1:0]     r_v;
    logic [NST:0]       en;

    always_comb begin
        en[NST] = i_ready;
        for (int k = NST - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end
    assign o_ready = en[0];

    always_comb begin
        n_st[0].work = i_num[bpc_pkg::WORD_W-1] ? 64'(-i_num) : 64'(i_num);
        n_st[0].rem  = '0;
        n_st[0].den  = i_den[bpc_pkg::DEN_W-1] ? 31'(-i_den) : 31'(i_den);
        n_st[0].neg  = i_num[bpc_pkg::WORD_W-1] ^ i_den[bpc_pkg::DEN_W-1];
        n_st[0].side = i_side;
        for (int k = 1; k <= NSTEP; k++) begin
            n_st[k] = div_step(r_st[k-1]);
        end
        n_st[NST-1]      = r_st[NST-2];
        n_st[NST-1].work = r_st[NST-2].neg ? (~r_st[NST-2].work + 64'd1)
                                           : r_st[NST-2].work;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            if (en[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_valid = r_v[NST-1];
    assign o_quo   = $signed(r_st[NST-1].work);
    assign o_side  = r_st[NST-1].side;

endmodule

FILE: rtl/barometric_pressure_compensation.sv
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// Factory-calibration compensation of raw temperature and pressure readings.
// ----------------------------------------------------------------------------
// channel  | dir | payload                                       | handshake
// i_req    | in  | raw_temperature, raw_pressure                 | valid/ready
// o_rsp    | out | temperature_centi, pressure_q8, pressure_inv. | valid/ready
// i_cfg_*  | in  | index, 64-bit data                            | write enable
//
// One request per cycle while responses are accepted; the pipeline consists of
// the 8 front stages, the divider (one stage per DIV_BITS quotient
// bits plus sign stages) and the 5 back stages.
// Synchronous reset clears the stage valid bits and the coefficients.
// Each stage advances when empty or when the next stage advances, so bubbles
// close up behind a stalled response.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation #(
    parameter int DIV_BITS = bpc_pkg::DIV_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    bpc_in_if.sink                            i_req,
    bpc_out_if.source                         o_rsp,
    input  logic                              i_cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bpc_pkg::CFG_W-1:0]         i_cfg_data
);

    // configuration
    logic [47:0] r_temp_coeffs;
    logic [63:0] r_press_lo;
    logic [63:0] r_press_hi;
    logic [15:0] r_press_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_coeffs <= '0;
            r_press_lo    <= '0;
            r_press_hi    <= '0;
            r_press_last  <= '0;
        end else if (i_cfg_we) begin
            case (bpc_pkg::t_cfg_idx'(i_cfg_idx))
                bpc_pkg::CFG_TEMP:       r_temp_coeffs <= i_cfg_data[47:0];
                bpc_pkg::CFG_PRESS_LOW:  r_press_lo    <= i_cfg_data;
                bpc_pkg::CFG_PRESS_HIGH: r_press_hi    <= i_cfg_data;
                bpc_pkg::CFG_PRESS_LAST: r_press_last  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic [15:0]        t1;
    logic signed [15:0] t2, t3, p2, p3, p5, p7, p8;
    logic signed [63:0] p1_x, p4_x, p6_x, p8_x, p9_x;
    assign t1   = r_temp_coeffs[15:0];
    assign t2   = r_temp_coeffs[31:16];
    assign t3   = r_temp_coeffs[47:32];
    assign p1_x = {48'b0, r_press_lo[15:0]};
    assign p2   = r_press_lo[31:16];
    assign p3   = r_press_lo[47:32];
    assign p4_x = $signed(r_press_lo[63:48]);
    assign p5   = r_press_hi[15:0];
    assign p6_x = $signed(r_press_hi[31:16]);
    assign p7   = r_press_hi[47:32];
    assign p8   = r_press_hi[63:48];
    assign p8_x = p8;
    assign p9_x = $signed(r_press_last);

    // front pipeline control
    localparam int NF = 8;
    logic [NF-1:0] r_fv;
    logic [NF:0]   en_f;
    logic          div_ready;

    always_comb begin
        en_f[NF] = div_ready;
        for (int k = NF - 1; k >= 0; k--) begin
            en_f[k] = !r_fv[k] || en_f[k+1];
        end
    end
    assign i_req.ready = en_f[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else begin
            if (en_f[0]) begin
                r_fv[0] <= i_req.valid;
            end
            for (int k = 1; k < NF; k++) begin
                if (en_f[k]) begin
                    r_fv[k] <= r_fv[k-1];
                end
            end
        end
    end

    // stage A: temperature products
    logic signed [17:0] a_dt;
    logic signed [16:0] a_dd;
    logic signed [33:0] a_t1m, a_dsq;
    logic signed [33:0] r_a_t1m, r_a_dsq;
    logic [19:0]        r_a_rp;
    assign a_dt  = $signed({1'b0, i_req.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
    assign a_dd  = $signed({1'b0, i_req.raw_temperature[19:4]}) - $signed({1'b0, t1});
    assign a_t1m = a_dt * t2;
    assign a_dsq = a_dd * a_dd;

    always_ff @(posedge i_clk) begin
        if (en_f[0]) begin
            r_a_t1m <= a_t1m;
            r_a_dsq <= a_dsq;
            r_a_rp  <= i_req.raw_pressure;
        end
    end

    // stage B
    logic signed [21:0] b_dq;
    logic signed [37:0] b_v2m;
    logic signed [22:0] r_b_v1;
    logic signed [37:0] r_b_v2m;
    logic [19:0]        r_b_rp;
    assign b_dq  = r_a_dsq[33:12];
    assign b_v2m = b_dq * t3;

    always_ff @(posedge i_clk) begin
        if (en_f[1]) begin
            r_b_v1  <= r_a_t1m[33:11];
            r_b_v2m <= b_v2m;
            r_b_rp  <= r_a_rp;
        end
    end

    // stage C: t_fine
    logic signed [23:0] c_v2;
    logic signed [24:0] c_tf;
    logic signed [25:0] c_pv;
    logic signed [24:0] r_c_tf;
    logic signed [25:0] r_c_pv;
    logic [19:0]        r_c_rp;
    assign c_v2 = r_b_v2m[37:14];
    assign c_tf = r_b_v1 + c_v2;
    assign c_pv = 26'(r_b_v1 + c_v2 - bpc_pkg::T_OFFSET);

    always_ff @(posedge i_clk) begin
        if (en_f[2]) begin
            r_c_tf <= c_tf;
            r_c_pv <= c_pv;
            r_c_rp <= r_b_rp;
        end
    end

    // stage D: temperature output, first pressure products
    logic signed [27:0] d_tf, d_t5, d_tq;
    logic signed [14:0] d_temp;
    logic signed [51:0] d_sq;
    logic signed [41:0] d_m5, d_m2;
    logic signed [51:0] r_d_sq;
    logic signed [41:0] r_d_m5, r_d_m2;
    logic signed [14:0] r_d_temp;
    logic [19:0]        r_d_rp;
    assign d_tf = r_c_tf;
    assign d_t5 = (d_tf <<< 2) + d_tf;
    assign d_tq = d_t5[27] ? ((d_t5 + 28'sd255) >>> 8) : (d_t5 >>> 8);
    always_comb begin
        if (d_tq < bpc_pkg::TEMP_MIN) begin
            d_temp = 15'(bpc_pkg::TEMP_MIN);
        end else if (d_tq > bpc_pkg::TEMP_MAX) begin
            d_temp = 15'(bpc_pkg::TEMP_MAX);
        end else begin
            d_temp = d_tq[14:0];
        end
    end
    assign d_sq = r_c_pv * r_c_pv;
    assign d_m5 = r_c_pv * p5;
    assign d_m2 = r_c_pv * p2;

    always_ff @(posedge i_clk) begin
        if (en_f[3]) begin
            r_d_sq   <= d_sq;
            r_d_m5   <= d_m5;
            r_d_m2   <= d_m2;
            r_d_temp <= d_temp;
            r_d_rp   <= r_c_rp;
        end
    end

    // stage E
    logic signed [63:0] e_sq, e_x6, e_x3, e_p3;
    logic signed [63:0] r_e_x6, r_e_x3;
    logic signed [41:0] r_e_m5, r_e_m2;
    logic signed [14:0] r_e_temp;
    logic [19:0]        r_e_rp;
    assign e_sq = r_d_sq;
    assign e_p3 = p3;
    assign e_x6 = e_sq * p6_x;
    assign e_x3 = e_sq * e_p3;

    always_ff @(posedge i_clk) begin
        if (en_f[4]) begin
            r_e_x6   <= e_x6;
            r_e_x3   <= e_x3;
            r_e_m5   <= r_d_m5;
            r_e_m2   <= r_d_m2;
            r_e_temp <= r_d_temp;
            r_e_rp   <= r_d_rp;
        end
    end

    // stage F: var1/var2 sums
    logic signed [63:0] f_m5, f_m2, f_v2, f_v1;
    logic signed [63:0] r_f_v2, r_f_v1;
    logic signed [14:0] r_f_temp;
    logic [19:0]        r_f_rp;
    assign f_m5 = r_e_m5;
    assign f_m2 = r_e_m2;
    assign f_v2 = r_e_x6 + (f_m5 <<< 17) + (p4_x <<< 35);
    assign f_v1 = (r_e_x3 >>> 8) + (f_m2 <<< 12) + 64'sh0000_8000_0000_0000;

    always_ff @(posedge i_clk) begin
        if (en_f[5]) begin
            r_f_v2   <= f_v2;
            r_f_v1   <= f_v1;
            r_f_temp <= r_e_temp;
            r_f_rp   <= r_e_rp;
        end
    end

    // stage G
    logic [20:0]        g_rpn;
    logic signed [63:0] g_prod, g_pn;
    logic signed [63:0] r_g_prod, r_g_pn;
    logic signed [14:0] r_g_temp;
    assign g_rpn  = bpc_pkg::P_BASE - {1'b0, r_f_rp};
    assign g_prod = r_f_v1 * p1_x;
    assign g_pn   = $signed({12'b0, g_rpn, 31'b0}) - r_f_v2;

    always_ff @(posedge i_clk) begin
        if (en_f[6]) begin
            r_g_prod <= g_prod;
            r_g_pn   <= g_pn;
            r_g_temp <= r_f_temp;
        end
    end

    // stage H: dividend and divisor
    logic signed [63:0] h_num;
    logic signed [63:0] r_h_num;
    logic signed [30:0] r_h_den;
    bpc_pkg::t_side     r_h_side;
    assign h_num = r_g_pn * $signed({52'b0, bpc_pkg::NUM_SCALE});

    always_ff @(posedge i_clk) begin
        if (en_f[7]) begin
            r_h_num          <= h_num;
            r_h_den          <= r_g_prod[63:33];
            r_h_side.temp    <= r_g_temp;
            r_h_side.invalid <= (r_g_prod[63:33] == '0);
        end
    end

    // divider
    logic               dv_valid;
    logic signed [63:0] dv_quo;
    bpc_pkg::t_side     dv_side;

    localparam int NB = 5;
    logic [NB-1:0] r_bv;
    logic [NB:0]   en_b;

    bpc_divider #(
        .STEP_BITS (DIV_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_fv[NF-1]),
        .o_ready (div_ready),
        .i_num   (r_h_num),
        .i_den   (r_h_den),
        .i_side  (r_h_side),
        .o_valid (dv_valid),
        .i_ready (en_b[0]),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    // back pipeline control
    always_comb begin
        en_b[NB] = o_rsp.ready;
        for (int k = NB - 1; k >= 0; k--) begin
            en_b[k] = !r_bv[k] || en_b[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
        end else begin
            if (en_b[0]) begin
                r_bv[0] <= dv_valid;
            end
            for (int k = 1; k < NB; k++) begin
                if (en_b[k]) begin
                    r_bv[k] <= r_bv[k-1];
                end
            end
        end
    end

    // P1: (p>>13)^2 partial products, P8 term
    logic signed [63:0] p1_ps, p1_x8;
    logic [63:0]        p1_ll;
    logic [31:0]        p1_lh;
    logic [63:0]        r_p1_ll;
    logic [31:0]        r_p1_lh;
    logic signed [63:0] r_p1_x8, r_p1_q;
    bpc_pkg::t_side     r_p1_side;
    assign p1_ps = dv_quo >>> 13;
    assign p1_ll = p1_ps[31:0] * p1_ps[31:0];
    assign p1_lh = p1_ps[31:0] * p1_ps[63:32];
    assign p1_x8 = dv_quo * p8_x;

    always_ff @(posedge i_clk) begin
        if (en_b[0]) begin
            r_p1_ll   <= p1_ll;
            r_p1_lh   <= p1_lh;
            r_p1_x8   <= p1_x8;
            r_p1_q    <= dv_quo;
            r_p1_side <= dv_side;
        end
    end

    // P2
    logic signed [63:0] r_p2_sq, r_p2_x8, r_p2_q;
    bpc_pkg::t_side     r_p2_side;

    always_ff @(posedge i_clk) begin
        if (en_b[1]) begin
            r_p2_sq   <= $signed(r_p1_ll + {r_p1_lh[30:0], 1'b0, 32'b0});
            r_p2_x8   <= r_p1_x8;
            r_p2_q    <= r_p1_q;
            r_p2_side <= r_p1_side;
        end
    end

    // P3
    logic signed [63:0] p3_y;
    logic signed [63:0] r_p3_y, r_p3_x8, r_p3_q;
    bpc_pkg::t_side     r_p3_side;
    assign p3_y = r_p2_sq * p9_x;

    always_ff @(posedge i_clk) begin
        if (en_b[2]) begin
            r_p3_y    <= p3_y;
            r_p3_x8   <= r_p2_x8;
            r_p3_q    <= r_p2_q;
            r_p3_side <= r_p2_side;
        end
    end

    // P4
    logic signed [63:0] p4_s;
    logic signed [63:0] r_p4_s;
    bpc_pkg::t_side     r_p4_side;
    assign p4_s = r_p3_q + (r_p3_y >>> 25) + (r_p3_x8 >>> 19);

    always_ff @(posedge i_clk) begin
        if (en_b[3]) begin
            r_p4_s    <= p4_s;
            r_p4_side <= r_p3_side;
        end
    end

    // P5: response register
    logic [31:0]        p5_p7;
    logic [31:0]        p5_press;
    logic [31:0]        r_o_press;
    logic signed [14:0] r_o_temp;
    logic               r_o_inv;
    assign p5_p7    = {{12{p7[15]}}, p7, 4'b0};
    assign p5_press = r_p4_side.invalid ? '0 : (r_p4_s[39:8] + p5_p7);

    always_ff @(posedge i_clk) begin
        if (en_b[4]) begin
            r_o_press <= p5_press;
            r_o_temp  <= r_p4_side.temp;
            r_o_inv   <= r_p4_side.invalid;
        end
    end

    assign o_rsp.valid             = r_bv[NB-1];
    assign o_rsp.temperature_centi = r_o_temp;
    assign o_rsp.pressure_q8       = r_o_press;
    assign o_rsp.pressure_invalid  = r_o_inv;

    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.pressure_invalid |-> o_rsp.pressure_q8 == '0)
        else $error("invalid response with nonzero pressure");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.temperature_centi >= 15'(bpc_pkg::TEMP_MIN))
                     && (o_rsp.temperature_centi <= 15'(bpc_pkg::TEMP_MAX)))
        else $error("temperature outside saturation range");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp.valid && (r_fv == '0) && (r_bv == '0))
        else $error("pipeline not empty after reset");

endmodule
